>>> rtl/scct_pkg.sv
package scct_pkg;

  localparam int POS_W  = 20;
  localparam int RAD_W  = 18;
  localparam int QA_W   = 44;
  localparam int M_W    = 43;
  localparam int QC_W   = 42;
  localparam int WIDE_W = 86;
  localparam int SQ_STEPS = WIDE_W / 2;
  localparam int ROOT_W = 43;
  localparam int TQ_W   = 17;
  localparam int FRAC_T = 16;
  localparam int DIV_W  = 61;
  localparam int HALF_W = 22;
  localparam logic [TQ_W-1:0] Q16_ONE = TQ_W'(65536);

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_OVERLAP,
    KIND_SWEPT
  } kind_e;

  typedef struct packed {
    logic signed [POS_W-1:0] first_start_x;
    logic signed [POS_W-1:0] first_start_y;
    logic signed [POS_W-1:0] first_end_x;
    logic signed [POS_W-1:0] first_end_y;
    logic        [RAD_W-1:0] first_radius;
    logic signed [POS_W-1:0] second_start_x;
    logic signed [POS_W-1:0] second_start_y;
    logic signed [POS_W-1:0] second_end_x;
    logic signed [POS_W-1:0] second_end_y;
    logic        [RAD_W-1:0] second_radius;
  } scct_in_t;

  typedef struct packed {
    logic            hit;
    logic            endpoint_overlap;
    logic [TQ_W-1:0] time_enter;
    logic [TQ_W-1:0] time_exit;
  } scct_out_t;

  // classified pair handed from front to back
  typedef struct packed {
    kind_e           kind;
    logic [QA_W-1:0] qa;
    logic [M_W-1:0]  m;
    logic [QC_W-1:0] qc;
  } scct_job_t;

endpackage

>>> rtl/scct_front.sv
module scct_front
  import scct_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  logic      in_valid_i,
  input  scct_in_t  in_data_i,
  output logic      job_valid_o,
  output scct_job_t job_o
);

  logic [3:0] v_q;

  logic signed [20:0] abx_q, aby_q, ab1x_q, ab1y_q;
  logic signed [21:0] vx_q, vy_q;
  logic [18:0]        rab_q;

  logic [40:0]        sax_q, say_q, sbx_q, sby_q;
  logic [42:0]        svx_q, svy_q;
  logic signed [42:0] dvx_q, dvy_q;
  logic [37:0]        rr_q;

  logic [41:0]        d0_q, d1_q;
  logic [QA_W-1:0]    qa_q;
  logic signed [43:0] qb_q;
  logic [37:0]        rr3_q;

  logic signed [43:0] neg;
  logic [43:0]        negu;
  logic               overlap, swept;
  scct_job_t          job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[2:0], in_valid_i};
    end
  end

  // differences
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      abx_q  <= 21'($signed(in_data_i.second_start_x)) - 21'($signed(in_data_i.first_start_x));
      aby_q  <= 21'($signed(in_data_i.second_start_y)) - 21'($signed(in_data_i.first_start_y));
      ab1x_q <= 21'($signed(in_data_i.second_end_x)) - 21'($signed(in_data_i.first_end_x));
      ab1y_q <= 21'($signed(in_data_i.second_end_y)) - 21'($signed(in_data_i.first_end_y));
      vx_q   <= 22'($signed(in_data_i.second_end_x)) - 22'($signed(in_data_i.second_start_x))
              - 22'($signed(in_data_i.first_end_x)) + 22'($signed(in_data_i.first_start_x));
      vy_q   <= 22'($signed(in_data_i.second_end_y)) - 22'($signed(in_data_i.second_start_y))
              - 22'($signed(in_data_i.first_end_y)) + 22'($signed(in_data_i.first_start_y));
      rab_q  <= 19'(in_data_i.first_radius) + 19'(in_data_i.second_radius);
    end
  end

  // products
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sax_q <= 41'(42'(abx_q) * 42'(abx_q));
      say_q <= 41'(42'(aby_q) * 42'(aby_q));
      sbx_q <= 41'(42'(ab1x_q) * 42'(ab1x_q));
      sby_q <= 41'(42'(ab1y_q) * 42'(ab1y_q));
      svx_q <= 43'(44'(vx_q) * 44'(vx_q));
      svy_q <= 43'(44'(vy_q) * 44'(vy_q));
      dvx_q <= 43'(vx_q) * 43'(abx_q);
      dvy_q <= 43'(vy_q) * 43'(aby_q);
      rr_q  <= 38'(rab_q) * 38'(rab_q);
    end
  end

  // sums
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d0_q  <= 42'(sax_q) + 42'(say_q);
      d1_q  <= 42'(sbx_q) + 42'(sby_q);
      qa_q  <= 44'(svx_q) + 44'(svy_q);
      qb_q  <= 44'(dvx_q) + 44'(dvy_q);
      rr3_q <= rr_q;
    end
  end

  // classify: overlap at either end, or entry root inside the frame
  always_comb begin
    neg     = -qb_q;
    negu    = neg;
    overlap = (d0_q <= 42'(rr3_q)) || (d1_q <= 42'(rr3_q));
    swept   = !neg[43] && (negu != '0) && (negu < qa_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      job_q.kind <= overlap ? KIND_OVERLAP : (swept ? KIND_SWEPT : KIND_NONE);
      job_q.qa   <= qa_q;
      job_q.m    <= negu[M_W-1:0];
      job_q.qc   <= d0_q - 42'(rr3_q);
    end
  end

  assign job_valid_o = v_q[3];
  assign job_o       = job_q;

endmodule

>>> rtl/scct_fifo.sv
module scct_fifo
  import scct_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  scct_job_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output scct_job_t data_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  scct_job_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  function automatic logic [PTR_W-1:0] wrap_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wrap_inc(wr_q);
      if (pop_i)  rd_q <= wrap_inc(rd_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

endmodule

>>> rtl/scct_back.sv
module scct_back
  import scct_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  scct_job_t job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output scct_out_t out_data_o
);

  localparam int DIV_STEPS = TQ_W;

  typedef struct packed {
    kind_e             kind;
    logic [QA_W-1:0]   qa;
    logic [M_W-1:0]    m;
    logic [WIDE_W-1:0] num;
    logic [WIDE_W-1:0] res;
  } sq_t;

  typedef struct packed {
    kind_e            kind;
    logic [QA_W-1:0]  qa;
    logic [DIV_W-1:0] re;
    logic [DIV_W-1:0] rx;
    logic [TQ_W-1:0]  qe;
    logic [TQ_W-1:0]  qx;
  } dv_t;

  logic adv;

  // partial products
  logic            pp_v_q;
  kind_e           pp_kind_q;
  logic [QA_W-1:0] pp_qa_q;
  logic [M_W-1:0]  pp_m_q;
  logic [43:0]     mm_ll_q, ac_ll_q, ac_hl_q;
  logic [42:0]     mm_lh_q;
  logic [41:0]     mm_hh_q, ac_lh_q, ac_hh_q;

  // wide sums
  logic              sm_v_q;
  kind_e             sm_kind_q;
  logic [QA_W-1:0]   sm_qa_q;
  logic [M_W-1:0]    sm_m_q;
  logic [WIDE_W-1:0] bb_q, ac_q;

  sq_t               sq_q [SQ_STEPS+1];
  sq_t               sq_d [SQ_STEPS+1];
  logic [SQ_STEPS:0] sq_v_q;
  sq_t               sq_c;

  dv_t                dv_q [DIV_STEPS+1];
  dv_t                dv_d [DIV_STEPS+1];
  logic [DIV_STEPS:0] dv_v_q;
  dv_t                dv_init;
  logic [ROOT_W-1:0]  root, root_c;

  logic      out_v_q;
  scct_out_t out_q, out_d;

  function automatic sq_t sq_step(sq_t x, logic [WIDE_W-1:0] bitv);
    sq_t               y;
    logic [WIDE_W-1:0] trial;
    y     = x;
    trial = x.res + bitv;
    if (x.num >= trial) begin
      y.num = x.num - trial;
      y.res = (x.res >> 1) + bitv;
    end else begin
      y.res = x.res >> 1;
    end
    return y;
  endfunction

  function automatic dv_t dv_step(dv_t x, int b);
    dv_t              y;
    logic [DIV_W-1:0] dsh;
    y   = x;
    dsh = DIV_W'(x.qa) << b;
    if (x.re >= dsh) begin
      y.re    = x.re - dsh;
      y.qe[b] = 1'b1;
    end
    if (x.rx >= dsh) begin
      y.rx    = x.rx - dsh;
      y.qx[b] = 1'b1;
    end
    return y;
  endfunction

  assign adv   = !(out_v_q && out_stall_i);
  assign pop_o = adv && job_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_v_q  <= 1'b0;
      sm_v_q  <= 1'b0;
      sq_v_q  <= '0;
      dv_v_q  <= '0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      pp_v_q  <= job_valid_i;
      sm_v_q  <= pp_v_q;
      sq_v_q  <= {sq_v_q[SQ_STEPS-1:0], sm_v_q};
      dv_v_q  <= {dv_v_q[DIV_STEPS-1:0], sq_v_q[SQ_STEPS]};
      out_v_q <= dv_v_q[DIV_STEPS];
    end
  end

  // split m, qa and qc at bit 22 into halves for m*m and qa*qc
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pp_kind_q <= job_i.kind;
      pp_qa_q   <= job_i.qa;
      pp_m_q    <= job_i.m;
      mm_ll_q   <= 44'(job_i.m[HALF_W-1:0]) * 44'(job_i.m[HALF_W-1:0]);
      mm_lh_q   <= 43'(job_i.m[HALF_W-1:0]) * 43'(job_i.m[M_W-1:HALF_W]);
      mm_hh_q   <= 42'(job_i.m[M_W-1:HALF_W]) * 42'(job_i.m[M_W-1:HALF_W]);
      ac_ll_q   <= 44'(job_i.qa[HALF_W-1:0]) * 44'(job_i.qc[HALF_W-1:0]);
      ac_lh_q   <= 42'(job_i.qa[HALF_W-1:0]) * 42'(job_i.qc[QC_W-1:HALF_W]);
      ac_hl_q   <= 44'(job_i.qa[QA_W-1:HALF_W]) * 44'(job_i.qc[HALF_W-1:0]);
      ac_hh_q   <= 42'(job_i.qa[QA_W-1:HALF_W]) * 42'(job_i.qc[QC_W-1:HALF_W]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sm_kind_q <= pp_kind_q;
      sm_qa_q   <= pp_qa_q;
      sm_m_q    <= pp_m_q;
      bb_q <= (WIDE_W'(mm_hh_q) << (2 * HALF_W)) + (WIDE_W'(mm_lh_q) << (HALF_W + 1))
            + WIDE_W'(mm_ll_q);
      ac_q <= (WIDE_W'(ac_hh_q) << (2 * HALF_W)) + (WIDE_W'(ac_lh_q) << HALF_W)
            + (WIDE_W'(ac_hl_q) << HALF_W) + WIDE_W'(ac_ll_q);
    end
  end

  // drop the swept case when the discriminant is negative
  always_comb begin
    sq_c.kind = sm_kind_q;
    sq_c.qa   = sm_qa_q;
    sq_c.m    = sm_m_q;
    sq_c.res  = '0;
    sq_c.num  = '0;
    if (sm_kind_q == KIND_SWEPT) begin
      if (ac_q <= bb_q) begin
        sq_c.num = bb_q - ac_q;
      end else begin
        sq_c.kind = KIND_NONE;
      end
    end
  end

  always_comb begin
    sq_d[0] = sq_c;
    for (int k = 0; k < SQ_STEPS; k++) begin
      sq_d[k+1] = sq_step(sq_q[k], WIDE_W'(1) << (WIDE_W - 2 - 2 * k));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= SQ_STEPS; k++) begin
        sq_q[k] <= sq_d[k];
      end
    end
  end

  // numerators m - s and m + s, scaled to 16 fraction bits
  always_comb begin
    root   = sq_q[SQ_STEPS].res[ROOT_W-1:0];
    root_c = (root > sq_q[SQ_STEPS].m) ? sq_q[SQ_STEPS].m : root;
    dv_init.kind = sq_q[SQ_STEPS].kind;
    dv_init.qa   = sq_q[SQ_STEPS].qa;
    dv_init.re   = DIV_W'(sq_q[SQ_STEPS].m - root_c) << FRAC_T;
    dv_init.rx   = (DIV_W'(sq_q[SQ_STEPS].m) + DIV_W'(root_c)) << FRAC_T;
    dv_init.qe   = '0;
    dv_init.qx   = '0;
  end

  always_comb begin
    dv_d[0] = dv_init;
    for (int j = 0; j < DIV_STEPS; j++) begin
      dv_d[j+1] = dv_step(dv_q[j], DIV_STEPS - 1 - j);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j <= DIV_STEPS; j++) begin
        dv_q[j] <= dv_d[j];
      end
    end
  end

  always_comb begin
    out_d.hit              = (dv_q[DIV_STEPS].kind != KIND_NONE);
    out_d.endpoint_overlap = (dv_q[DIV_STEPS].kind == KIND_OVERLAP);
    out_d.time_enter       = '0;
    out_d.time_exit        = '0;
    if (dv_q[DIV_STEPS].kind == KIND_SWEPT) begin
      out_d.time_enter = (dv_q[DIV_STEPS].qe > Q16_ONE) ? Q16_ONE : dv_q[DIV_STEPS].qe;
      out_d.time_exit  = (dv_q[DIV_STEPS].qx > Q16_ONE) ? Q16_ONE : dv_q[DIV_STEPS].qx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/swept_circle_collision_test_unit.sv
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_stall_o  in_data_i  (scct_in_t, two circles)
// out       output     out_valid_o / out_stall_i out_data_o (scct_out_t, hit and times)
//
// One pair is taken per cycle while in_stall_o is low. The back pipeline
// holds 43 stages of the bit-per-stage square root and 17 stages of the
// two restoring dividers that form the entry and exit times.
// Reset (rst_ni low, asynchronous) clears all valid bits and FIFO pointers.
// An output stall freezes the back pipeline; the front keeps filling the
// FIFO and raises in_stall_o only once the FIFO is full.
module swept_circle_collision_test_unit
  import scct_pkg::*;
#(
  parameter int FIFO_DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  scct_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output scct_out_t out_data_o
);

  logic      fifo_full, fifo_empty, fifo_pop;
  logic      front_adv;
  logic      job_valid;
  scct_job_t job, job_head;

  // Advance the front only while the FIFO can take its last stage.
  assign front_adv  = !fifo_full;
  assign in_stall_o = !front_adv;

  // Front: differences, products and sums, then classify each pair as an
  // endpoint overlap, a candidate swept hit or a miss.
  scct_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (front_adv),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  // Short queue that decouples front and back stalls.
  scct_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_adv && job_valid),
    .data_i  (job),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .empty_o (fifo_empty),
    .data_o  (job_head)
  );

  // Back: discriminant, square root, division, clamp and output register.
  scct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!fifo_empty),
    .job_i       (job_head),
    .pop_o       (fifo_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/scct_checker.sv
module scct_checker
  import scct_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input scct_out_t out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |->
      out_data_o.time_enter == '0 && out_data_o.time_exit == '0 &&
      !out_data_o.endpoint_overlap)
    else $error("miss with nonzero fields");

  a_overlap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.endpoint_overlap |->
      out_data_o.hit && out_data_o.time_enter == '0 && out_data_o.time_exit == '0)
    else $error("overlap with nonzero times");

  a_time_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit && !out_data_o.endpoint_overlap |->
      out_data_o.time_enter <= out_data_o.time_exit && out_data_o.time_exit <= Q16_ONE)
    else $error("swept times out of order or range");

  a_reset_idle: assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind swept_circle_collision_test_unit scct_checker u_scct_checker (.*);
